@@ src/scnal_pkg.sv @@
// Shared types and constants for the start code unit splitter.
// Used by the front, queue, back and top-level modules. No dependencies.
package scnal_pkg;

  // Input command codes
  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_EOS  = 1'b1
  } cmd_e;

  localparam logic [7:0] ZeroByte  = 8'h00;
  localparam logic [7:0] StartByte = 8'h01;

  // Result slots produced by one input word
  localparam int unsigned MaxRes = 3;

  // One result word
  typedef struct packed {
    logic [7:0] ubyte;
    logic       uend;
    logic       uerr;
  } res_t;

  // Group of results caused by one input word, slot 0 first
  typedef struct packed {
    logic [1:0]              cnt;
    res_t [MaxRes-1:0]       res;
  } grp_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

@@ src/start_code_nal_splitter.sv @@
// Start code unit splitter, top level. Result groups are registered in the
// queue, then each result word in the output register. Input takes one word
// per cycle while the queue has room; output gives one word per cycle while
// out_stall_i is low; a byte causing k results gives k words. Reset (async,
// active low) empties the queue and output and returns to the leading phase.
module start_code_nal_splitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] unit_byte_o,
  output logic       unit_end_o,
  output logic       error_o
);
  import scnal_pkg::*;

  grp_t   grp;
  grp_t   head;
  qstat_t qstat;
  logic   push;
  logic   pop;

  scnal_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .data_i     (data_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .grp_o      (grp)
  );

  scnal_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .grp_i   (grp),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  scnal_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .unit_byte_o (unit_byte_o),
    .unit_end_o  (unit_end_o),
    .error_o     (error_o)
  );

endmodule

@@ src/scnal_front.sv @@
// Front end: accepts input words, tracks held bytes and start code state,
// and builds one result group per word. Depends on scnal_pkg.
module scnal_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cmd_i,
  input  logic [7:0]        data_i,
  input  scnal_pkg::qstat_t qstat_i,
  output logic              push_o,
  output scnal_pkg::grp_t   grp_o
);
  import scnal_pkg::*;

  logic       in_payload_q, in_payload_d;
  logic [1:0] zero_run_q, zero_run_d;
  logic [7:0] held_byte_q, held_byte_d;
  logic       held_valid_q, held_valid_d;
  logic [1:0] n_held;
  logic       accept;
  grp_t       grp;

  // Stall whenever the queue has no room for a group
  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;

  assign n_held = {1'b0, held_valid_q} + zero_run_q;

  // Classify the word and build its result group
  always_comb begin
    grp          = '0;
    in_payload_d = in_payload_q;
    zero_run_d   = zero_run_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;

    // Held bytes in stream order: held byte (if valid), then zeros
    for (int i = 0; i < MaxRes; i++) begin
      grp.res[i].ubyte = (held_valid_q && i == 0) ? held_byte_q : ZeroByte;
    end

    priority if (cmd_e'(cmd_i) == CMD_EOS) begin
      // Flush everything held and mark the last byte
      grp.cnt = n_held;
      for (int i = 0; i < MaxRes; i++) begin
        grp.res[i].uend = (n_held != 2'd0) && (2'(i) == n_held - 2'd1);
      end
      in_payload_d = 1'b0;
      zero_run_d   = 2'd0;
      held_byte_d  = ZeroByte;
      held_valid_d = 1'b0;
    end else if (data_i == ZeroByte) begin
      if (zero_run_q < 2'd2) begin
        zero_run_d = zero_run_q + 2'd1;
      end else begin
        // Third zero: oldest held byte leaves, a zero takes its place
        grp.cnt      = {1'b0, held_valid_q};
        held_byte_d  = ZeroByte;
        held_valid_d = 1'b1;
      end
    end else if (data_i == StartByte && zero_run_q == 2'd2) begin
      // Start code: close previous unit on the held byte, open new one
      grp.cnt         = held_valid_q ? 2'd3 : 2'd2;
      grp.res[0].uend = held_valid_q && in_payload_q;
      held_byte_d     = StartByte;
      held_valid_d    = 1'b1;
      zero_run_d      = 2'd0;
      in_payload_d    = 1'b1;
    end else if (!in_payload_q && data_i != StartByte) begin
      // Garbage in the leading phase (before a start code): report and drop
      grp.cnt    = 2'd1;
      grp.res[0] = '{ubyte: ZeroByte, uend: 1'b0, uerr: 1'b1};
    end else begin
      // Plain byte: release held bytes, hold this one
      grp.cnt      = n_held;
      held_byte_d  = data_i;
      held_valid_d = 1'b1;
      zero_run_d   = 2'd0;
    end
  end

  assign push_o = accept && (grp.cnt != 2'd0);
  assign grp_o  = grp;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      zero_run_q   <= 2'd0;
      held_byte_q  <= ZeroByte;
      held_valid_q <= 1'b0;
    end else if (accept) begin
      in_payload_q <= in_payload_d;
      zero_run_q   <= zero_run_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
    end
  end

endmodule

@@ src/scnal_queue.sv @@
// Two-entry queue of result groups between front and back.
// Depends on scnal_pkg.
module scnal_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  scnal_pkg::grp_t   grp_i,
  input  logic              pop_i,
  output scnal_pkg::grp_t   head_o,
  output scnal_pkg::qstat_t qstat_o
);
  import scnal_pkg::*;

  grp_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign head_o        = slot_q[rd_ptr_q];
  assign qstat_o.full  = (count_q == 2'd2);
  assign qstat_o.empty = (count_q == 2'd0);

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= grp_i;
  end

endmodule

@@ src/scnal_back.sv @@
// Back end: walks the head group one result at a time into the output
// register. Depends on scnal_pkg.
module scnal_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scnal_pkg::grp_t   head_i,
  input  scnal_pkg::qstat_t qstat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        unit_byte_o,
  output logic              unit_end_o,
  output logic              error_o
);
  import scnal_pkg::*;

  logic       out_valid_q;
  logic [1:0] idx_q;
  res_t       res_q;
  logic       load;
  logic       last;

  // Load a new word when the output register is free or draining
  assign load  = !qstat_i.empty && (!out_valid_q || !out_stall_i);
  assign last  = (idx_q == head_i.cnt - 2'd1);
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) res_q <= head_i.res[idx_q];
  end

  assign out_valid_o = out_valid_q;
  assign unit_byte_o = res_q.ubyte;
  assign unit_end_o  = res_q.uend;
  assign error_o     = res_q.uerr;

endmodule

@@ src/scnal_checker.sv @@
// Port-level checks for the start code unit splitter, bound to the top.
// Depends only on the top-level ports.
module scnal_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       cmd_i,
  input logic [7:0] data_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] unit_byte_o,
  input logic       unit_end_o,
  input logic       error_o
);

  // Stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(unit_byte_o)
      && $stable(unit_end_o) && $stable(error_o))
    else $error("stalled output word changed");

  // Error words carry no byte and no end mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> unit_byte_o == 8'h00 && !unit_end_o)
    else $error("error word with payload");

  // Reset clears the output valid by the next edge
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

  // No output word at the first edge after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output right after reset");

endmodule

bind start_code_nal_splitter scnal_checker u_scnal_checker (.*);

@@ sim/tb_start_code_nal_splitter.sv @@
// Testbench for start_code_nal_splitter: directed, back-pressure and random byte streams.
// A built-in predictor tracks the held bytes and checks every result word in order.
// Depends on src/scnal_pkg.sv and the RTL of the splitter.
`timescale 1ns / 100ps

module tb_start_code_nal_splitter;
  import scnal_pkg::*;

  typedef struct {
    cmd_e       cmd;
    logic [7:0] data;
  } stream_word_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       cmd_i       = 1'b0;
  logic [7:0] data_i      = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] unit_byte_o;
  logic       unit_end_o;
  logic       error_o;

  // Words waiting to be offered, and unit bytes the splitter still owes
  stream_word_t words_pending[$];
  res_t         unit_bytes_due[$];

  // Shadow of the splitter state
  bit         sh_in_payload = 1'b0;
  logic [1:0] sh_zero_run   = 2'd0;
  logic [7:0] sh_held_byte  = 8'h00;
  bit         sh_held_valid = 1'b0;

  bit          gaps_on    = 1'b1;
  int unsigned hold_req   = 0;
  int unsigned mismatches = 0;

  start_code_nal_splitter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .data_i     (data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .unit_byte_o(unit_byte_o),
    .unit_end_o (unit_end_o),
    .error_o    (error_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void owe_byte(logic [7:0] b, logic last, logic err);
    res_t r;
    r.ubyte = b;
    r.uend  = last;
    r.uerr  = err;
    unit_bytes_due.push_back(r);
  endfunction

  // Works out the unit bytes one accepted word releases and updates the shadow state
  function automatic void predict_unit_bytes(cmd_e cmd, logic [7:0] b);
    int unsigned total;
    int unsigned n;
    n = 0;
    if (cmd == CMD_EOS) begin
      // flush everything held, flag the last one, back to leading phase
      total = (sh_held_valid ? 1 : 0) + sh_zero_run;
      if (sh_held_valid) begin
        n++;
        owe_byte(sh_held_byte, n == total, 1'b0);
      end
      for (int i = 0; i < sh_zero_run; i++) begin
        n++;
        owe_byte(ZeroByte, n == total, 1'b0);
      end
      sh_in_payload = 1'b0;
      sh_zero_run   = 2'd0;
      sh_held_byte  = 8'h00;
      sh_held_valid = 1'b0;
    end else if (b == ZeroByte) begin
      // up to two zeros are held; a third pushes the held byte out
      if (sh_zero_run < 2) begin
        sh_zero_run++;
      end else begin
        if (sh_held_valid) owe_byte(sh_held_byte, 1'b0, 1'b0);
        sh_held_byte  = ZeroByte;
        sh_held_valid = 1'b1;
      end
    end else if (b == StartByte && sh_zero_run == 2) begin
      // start code: close the previous unit, open a new one
      if (sh_held_valid) owe_byte(sh_held_byte, sh_in_payload, 1'b0);
      owe_byte(ZeroByte, 1'b0, 1'b0);
      owe_byte(ZeroByte, 1'b0, 1'b0);
      sh_held_byte  = StartByte;
      sh_held_valid = 1'b1;
      sh_zero_run   = 2'd0;
      sh_in_payload = 1'b1;
    end else if (!sh_in_payload && b != StartByte) begin
      // garbage in the leading phase (before a start code) is dropped
      owe_byte(8'h00, 1'b0, 1'b1);
    end else begin
      if (sh_held_valid) owe_byte(sh_held_byte, 1'b0, 1'b0);
      for (int i = 0; i < sh_zero_run; i++) owe_byte(ZeroByte, 1'b0, 1'b0);
      sh_held_byte  = b;
      sh_held_valid = 1'b1;
      sh_zero_run   = 2'd0;
    end
  endfunction

  // Input driver: offers queued words, inserts random gaps after accepts
  initial begin
    int unsigned gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) begin
        predict_unit_bytes(words_pending[0].cmd, words_pending[0].data);
        void'(words_pending.pop_front());
        if (gaps_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 4);
      end
      if (in_valid_i && in_stall_o) begin
        // stalled word stays on the bus
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (words_pending.size() > 0) begin
        in_valid_i <= 1'b1;
        cmd_i      <= words_pending[0].cmd;
        data_i     <= words_pending[0].data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall: short random bursts, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned burst_left;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(1, 4) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result checker: each accepted word against the oldest owed unit byte
  initial begin
    res_t due;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (unit_bytes_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected word byte=%h end=%b err=%b", $realtime,
                     unit_byte_o, unit_end_o, error_o);
          mismatches++;
        end else begin
          due = unit_bytes_due.pop_front();
          if (unit_byte_o !== due.ubyte || unit_end_o !== due.uend || error_o !== due.uerr) begin
            if (mismatches < 10)
              $display("%0t: mismatch exp byte=%h end=%b err=%b got byte=%h end=%b err=%b",
                       $realtime, due.ubyte, due.uend, due.uerr,
                       unit_byte_o, unit_end_o, error_o);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic send_word(cmd_e cmd, logic [7:0] data);
    stream_word_t w;
    w.cmd  = cmd;
    w.data = data;
    words_pending.push_back(w);
  endtask

  // Sender holds back until every owed unit byte has come out
  task automatic wait_idle();
    while (words_pending.size() != 0 || unit_bytes_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Payload byte biased toward zeros and ones to provoke start codes
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 7))
      0, 1:    return ZeroByte;
      2:       return StartByte;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_directed();
    // two zeros then flush with junk data: second zero marks the end
    send_word(CMD_DATA, ZeroByte);
    send_word(CMD_DATA, ZeroByte);
    send_word(CMD_EOS, 8'hFF);
    // garbage and lone one in the leading phase
    send_word(CMD_DATA, 8'hFF);
    send_word(CMD_DATA, StartByte);
    send_word(CMD_DATA, 8'h80);
    // first start code, then payload with extremes
    send_word(CMD_DATA, ZeroByte);
    send_word(CMD_DATA, ZeroByte);
    send_word(CMD_DATA, StartByte);
    send_word(CMD_DATA, 8'h02);
    send_word(CMD_DATA, 8'hFF);
    // four-byte start code after a long zero run
    send_word(CMD_DATA, ZeroByte);
    send_word(CMD_DATA, ZeroByte);
    send_word(CMD_DATA, ZeroByte);
    send_word(CMD_DATA, StartByte);
    send_word(CMD_DATA, 8'hAA);
    // three-byte start code
    send_word(CMD_DATA, ZeroByte);
    send_word(CMD_DATA, ZeroByte);
    send_word(CMD_DATA, StartByte);
    send_word(CMD_DATA, 8'h7F);
    send_word(CMD_DATA, ZeroByte);
    send_word(CMD_EOS, 8'hA5);
    // flush with nothing held gives no word
    send_word(CMD_EOS, 8'h5A);
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_req = 120;
    for (int i = 0; i < 8; i++) begin
      send_word(CMD_DATA, ZeroByte);
      send_word(CMD_DATA, ZeroByte);
      send_word(CMD_DATA, StartByte);
      send_word(CMD_DATA, payload_byte());
      send_word(CMD_DATA, 8'($urandom_range(0, 255)));
    end
    send_word(CMD_EOS, 8'h00);
    wait_idle();
  endtask

  task automatic test_random_streams(int unsigned n_words);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4, 5, 6: begin
          // well-formed unit: optional leading zero, start code, payload
          if ($urandom_range(0, 2) == 0) begin
            send_word(CMD_DATA, ZeroByte);
            sent++;
          end
          send_word(CMD_DATA, ZeroByte);
          send_word(CMD_DATA, ZeroByte);
          send_word(CMD_DATA, StartByte);
          sent += 3;
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++) send_word(CMD_DATA, payload_byte());
          sent += len;
        end
        7: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) send_word(CMD_DATA, ZeroByte);
          sent += len;
        end
        8: begin
          send_word(CMD_EOS, 8'($urandom_range(0, 255)));
          sent++;
        end
        9: begin
          send_word(CMD_DATA, 8'($urandom_range(0, 255)));
          sent++;
        end
        10: begin
          send_word(CMD_DATA, StartByte);
          sent++;
        end
        default: begin
          // broken start code
          send_word(CMD_DATA, ZeroByte);
          send_word(CMD_DATA, ZeroByte);
          send_word(CMD_DATA, 8'($urandom_range(2, 255)));
          sent += 3;
        end
      endcase
    end
    send_word(CMD_EOS, 8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_streams(100);
    // last stretch at full rate on both sides
    gaps_on = 1'b0;
    test_random_streams(30);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && unit_bytes_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
